// File: hdl/lpf_pkg.sv
// Shared types, constants and table functions of the LPCM packet framer.
`default_nettype none

package lpf_pkg;

  // Packet geometry
  localparam int PACKET_SPACE = 2048;
  localparam int PES_OVERHEAD = 18;
  localparam int HDR_LEN      = 14;
  localparam int SPACE        = PACKET_SPACE - PES_OVERHEAD - HDR_LEN;

  localparam int MAX_SLOTS = 160;
  localparam int MIN_SLOTS = 40;
  localparam int MAX_CHAN  = 15;
  localparam int MAX_FRAME = MAX_SLOTS * MAX_CHAN * 3;
  localparam int MIN_FRAME = MIN_SLOTS * 2;

  localparam int RATE_W  = 3;
  localparam int CHAN_W  = 4;
  localparam int SLOT_W  = 8;
  localparam int FC_W    = 5;
  localparam int FRAME_W = $clog2(MAX_FRAME + 1);
  localparam int SPACE_W = $clog2(SPACE + 1);
  localparam int SUM_W   = ((FRAME_W > SPACE_W) ? FRAME_W : SPACE_W) + 1;
  localparam int FPP_W   = $clog2(SPACE / MIN_FRAME + 1);
  localparam int CNT_SUM_W = SPACE_W + 1;

  localparam int GROUP_MAX  = 12;
  localparam int GROUP_PAIR = 2;
  localparam int GIDX_W     = $clog2(GROUP_MAX);
  localparam int HIDX_W     = $clog2(HDR_LEN);
  localparam int IDX_W      = (GIDX_W > HIDX_W) ? GIDX_W : HIDX_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_RATE  = 2'd0,
    REG_CHAN  = 2'd1,
    REG_WIDTH = 2'd2
  } lpf_reg_t;

  localparam logic [RATE_W-1:0] RATE_RST  = 3'd0;
  localparam logic [CHAN_W-1:0] CHAN_RST  = 4'd2;
  localparam logic              WIDTH_RST = 1'b0;

  // Private header bytes
  localparam logic [7:0] HDR_STREAM_ID = 8'hA0;
  localparam logic [7:0] HDR_FRAMES    = 8'h0A;
  localparam logic [7:0] HDR_FIRST_AU  = 8'h09;
  localparam logic [7:0] HDR_LOW_NIB   = 8'h0F;
  localparam logic [7:0] HDR_WIDE24    = 8'h20;
  localparam logic [7:0] HDR_DYN_RANGE = 8'h80;

  localparam int HB_ID    = 0;
  localparam int HB_FC    = 1;
  localparam int HB_FRM   = 3;
  localparam int HB_AU    = 5;
  localparam int HB_WIDTH = 7;
  localparam int HB_RATE  = 8;
  localparam int HB_CHAN  = 10;
  localparam int HB_DRC   = 11;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [CHAN_W-1:0]  chan;
    logic               wide;
    logic               busy;
    logic               ok;
    logic               clear;
    logic [FPP_W-1:0]   fpp;
    logic [SPACE_W-1:0] plen;
  } lpf_cfg_t;

  typedef logic [GROUP_MAX-1:0][7:0] lpf_group_t;

  typedef struct packed {
    logic            err;
    logic            hdr;
    logic            pend;
    logic [FC_W-1:0] fc;
    lpf_group_t      data;
  } lpf_job_t;

  function automatic logic [SLOT_W-1:0] rate_slots(input logic [RATE_W-1:0] rate);
    logic [SLOT_W-1:0] s;
    case (rate)
      3'd0, 3'd3: s = 8'd40;
      3'd1, 3'd4: s = 8'd80;
      3'd2, 3'd5: s = 8'd160;
      default:    s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rate_bits(input logic [RATE_W-1:0] rate);
    logic [7:0] b;
    case (rate)
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h20;
      3'd3:    b = 8'h80;
      3'd4:    b = 8'h90;
      3'd5:    b = 8'hA0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Target order of a 24-bit group: high/mid bytes of each sample, then low bytes
  function automatic logic [GIDX_W-1:0] order24(input logic [GIDX_W-1:0] idx);
    logic [GIDX_W-1:0] s;
    case (idx)
      4'd0:    s = 4'd2;
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd5;
      4'd3:    s = 4'd4;
      4'd4:    s = 4'd8;
      4'd5:    s = 4'd7;
      4'd6:    s = 4'd11;
      4'd7:    s = 4'd10;
      4'd8:    s = 4'd0;
      4'd9:    s = 4'd3;
      4'd10:   s = 4'd6;
      4'd11:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [HIDX_W-1:0] idx,
                                          input logic [FC_W-1:0]   fc,
                                          input logic              wide,
                                          input logic [RATE_W-1:0] rate,
                                          input logic [CHAN_W-1:0] chan);
    logic [7:0]        b;
    logic [CHAN_W-1:0] cm1;
    cm1 = chan - 1'b1;
    case (idx)
      HIDX_W'(HB_ID):    b = HDR_STREAM_ID;
      HIDX_W'(HB_FC):    b = 8'(fc);
      HIDX_W'(HB_FRM):   b = HDR_FRAMES;
      HIDX_W'(HB_AU):    b = HDR_FIRST_AU;
      HIDX_W'(HB_WIDTH): b = HDR_LOW_NIB | (wide ? HDR_WIDE24 : 8'h00);
      HIDX_W'(HB_RATE):  b = HDR_LOW_NIB | rate_bits(rate);
      HIDX_W'(HB_CHAN):  b = 8'(cm1);
      HIDX_W'(HB_DRC):   b = HDR_DYN_RANGE;
      default:           b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lpf_if.sv
// Valid/ready stream interfaces for PCM input words and framed output words.
`default_nettype none

interface lpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pcm_byte;
  logic       buffer_end;

  modport source (output valid, output pcm_byte, output buffer_end, input ready);
  modport sink   (input valid, input pcm_byte, input buffer_end, output ready);
endinterface

interface lpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       packet_end;
  logic       run_last;
  logic       setup_error;

  modport source (output valid, output out_byte, output is_header, output packet_end,
                  output run_last, output setup_error, input ready);
  modport sink   (input valid, input out_byte, input is_header, input packet_end,
                  input run_last, input setup_error, output ready);
endinterface

`default_nettype wire

// File: hdl/lpf_cfg.sv
// Configuration registers and frames-per-packet derivation by repeated addition.
`default_nettype none

module lpf_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lpf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [lpf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [lpf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output lpf_pkg::lpf_cfg_t                     cfg
);

  typedef enum logic [1:0] {D_LOAD, D_RUN, D_IDLE} dstate_t;

  dstate_t                           state_r, state_nxt;
  logic [lpf_pkg::RATE_W-1:0]        rate_r, rate_nxt;
  logic [lpf_pkg::CHAN_W-1:0]        chan_r, chan_nxt;
  logic                              wide_r, wide_nxt;
  logic [lpf_pkg::FRAME_W-1:0]       frame_r, frame_nxt;
  logic [lpf_pkg::SPACE_W-1:0]       acc_r, acc_nxt;
  logic [lpf_pkg::FPP_W-1:0]         fpp_r, fpp_nxt;

  logic                              wr_hit;
  lpf_pkg::lpf_reg_t                 widx;
  logic [lpf_pkg::SLOT_W+lpf_pkg::CHAN_W-1:0] prod;
  logic [lpf_pkg::FRAME_W-1:0]       prod2;
  logic [lpf_pkg::FRAME_W-1:0]       frame_calc;
  logic [lpf_pkg::SUM_W-1:0]         sum;

  assign pready = 1'b1;
  assign widx   = lpf_pkg::lpf_reg_t'(paddr[lpf_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    case (widx)
      lpf_pkg::REG_RATE, lpf_pkg::REG_CHAN, lpf_pkg::REG_WIDTH: wr_hit = psel & penable & pwrite;
      default: wr_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (widx)
      lpf_pkg::REG_RATE:  prdata = lpf_pkg::CFG_DATA_W'(rate_r);
      lpf_pkg::REG_CHAN:  prdata = lpf_pkg::CFG_DATA_W'(chan_r);
      lpf_pkg::REG_WIDTH: prdata = lpf_pkg::CFG_DATA_W'(wide_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    prod       = lpf_pkg::rate_slots(rate_r) * chan_r;
    prod2      = lpf_pkg::FRAME_W'(prod) << 1;
    frame_calc = wide_r ? prod2 + lpf_pkg::FRAME_W'(prod) : prod2;
    sum        = lpf_pkg::SUM_W'(acc_r) + lpf_pkg::SUM_W'(frame_r);

    state_nxt = state_r;
    rate_nxt  = rate_r;
    chan_nxt  = chan_r;
    wide_nxt  = wide_r;
    frame_nxt = frame_r;
    acc_nxt   = acc_r;
    fpp_nxt   = fpp_r;

    case (state_r)
      D_LOAD: begin
        frame_nxt = frame_calc;
        acc_nxt   = '0;
        fpp_nxt   = '0;
        state_nxt = D_RUN;
      end
      D_RUN: begin
        // take one more frame while it still fits in the packet
        if (frame_r != '0 && sum <= lpf_pkg::SUM_W'(lpf_pkg::SPACE)) begin
          acc_nxt = lpf_pkg::SPACE_W'(sum);
          fpp_nxt = fpp_r + 1'b1;
        end else begin
          state_nxt = D_IDLE;
        end
      end
      D_IDLE: ;
      default: state_nxt = D_LOAD;
    endcase

    if (wr_hit) begin
      case (widx)
        lpf_pkg::REG_RATE:  rate_nxt = pwdata[lpf_pkg::RATE_W-1:0];
        lpf_pkg::REG_CHAN:  chan_nxt = pwdata[lpf_pkg::CHAN_W-1:0];
        lpf_pkg::REG_WIDTH: wide_nxt = pwdata[0];
        default: ;
      endcase
      state_nxt = D_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_LOAD;
      rate_r  <= lpf_pkg::RATE_RST;
      chan_r  <= lpf_pkg::CHAN_RST;
      wide_r  <= lpf_pkg::WIDTH_RST;
      frame_r <= '0;
      acc_r   <= '0;
      fpp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rate_r  <= rate_nxt;
      chan_r  <= chan_nxt;
      wide_r  <= wide_nxt;
      frame_r <= frame_nxt;
      acc_r   <= acc_nxt;
      fpp_r   <= fpp_nxt;
    end
  end

  always_comb begin
    cfg.rate  = rate_r;
    cfg.chan  = chan_r;
    cfg.wide  = wide_r;
    cfg.busy  = (state_r != D_IDLE);
    cfg.ok    = (fpp_r != '0);
    cfg.clear = wr_hit;
    cfg.fpp   = fpp_r;
    cfg.plen  = acc_r;
  end

endmodule

`default_nettype wire

// File: hdl/lpf_front.sv
// Front end: gather PCM words into groups and decide header, packet end and frame count.
`default_nettype none

module lpf_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lpf_in_if.sink                     in_if,
  input  wire lpf_pkg::lpf_cfg_t     cfg,
  input  wire logic                  q_full,
  output logic                       push,
  output lpf_pkg::lpf_job_t          push_job
);

  logic [7:0]                        store_r [lpf_pkg::GROUP_MAX];
  logic [lpf_pkg::GIDX_W-1:0]        fill_r, fill_nxt;
  logic [lpf_pkg::SPACE_W-1:0]       cnt_r, cnt_nxt;
  logic [lpf_pkg::FC_W-1:0]          fc_r, fc_nxt;

  logic                              accept;
  logic [lpf_pkg::GIDX_W-1:0]        gsize;
  logic                              last;
  logic [lpf_pkg::CNT_SUM_W-1:0]     cnt_sum;
  logic                              pend;
  logic                              hdr;
  logic [lpf_pkg::FC_W-1:0]          fc_new;

  assign in_if.ready = !cfg.busy && !q_full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    gsize   = cfg.wide ? lpf_pkg::GIDX_W'(lpf_pkg::GROUP_MAX)
                       : lpf_pkg::GIDX_W'(lpf_pkg::GROUP_PAIR);
    last    = (fill_r == gsize - 1'b1);
    cnt_sum = lpf_pkg::CNT_SUM_W'(cnt_r) + lpf_pkg::CNT_SUM_W'(gsize);
    pend    = cnt_sum >= lpf_pkg::CNT_SUM_W'(cfg.plen);
    hdr     = (cnt_r == '0);
    fc_new  = fc_r + lpf_pkg::FC_W'(cfg.fpp);

    push_job.err  = !cfg.ok;
    push_job.hdr  = hdr;
    push_job.pend = pend;
    push_job.fc   = fc_new;
    for (int i = 0; i < lpf_pkg::GROUP_MAX; i++) begin
      push_job.data[lpf_pkg::GIDX_W'(i)] = (lpf_pkg::GIDX_W'(i) == fill_r) ? in_if.pcm_byte
                                                                : store_r[lpf_pkg::GIDX_W'(i)];
    end

    // a bad setup turns every word into one error result
    push = accept && (!cfg.ok || last);

    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    fc_nxt   = fc_r;
    if (cfg.clear) begin
      fill_nxt = '0;
      cnt_nxt  = '0;
    end else if (accept && cfg.ok) begin
      if (last) begin
        fill_nxt = '0;
        cnt_nxt  = pend ? '0 : lpf_pkg::SPACE_W'(cnt_sum);
        if (hdr) begin
          fc_nxt = fc_new;
        end
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      fc_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      fc_r   <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cfg.ok && !cfg.clear) begin
      store_r[fill_r] <= in_if.pcm_byte;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lpf_queue.sv
// Short job queue between the front end and the output sequencer.
`default_nettype none

module lpf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire lpf_pkg::lpf_job_t     push_job,
  output logic                       full,
  output logic                       head_valid,
  output lpf_pkg::lpf_job_t          head,
  input  wire logic                  pop
);

  lpf_pkg::lpf_job_t              mem_r [lpf_pkg::QUEUE_DEPTH];
  logic [lpf_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [lpf_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [lpf_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count_r == lpf_pkg::QCNT_W'(lpf_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lpf_pkg::QPTR_W'(lpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lpf_pkg::QPTR_W'(lpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + lpf_pkg::QCNT_W'(do_push) - lpf_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lpf_back.sv
// Output sequencer: emit header bytes and reordered group bytes, one word per cycle while the output is not stalled.
`default_nettype none

module lpf_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lpf_pkg::lpf_cfg_t     cfg,
  input  wire logic                  head_valid,
  input  wire lpf_pkg::lpf_job_t     head,
  output logic                       pop,
  lpf_out_if.source                  out_if
);

  logic [lpf_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        hdr_done_r, hdr_done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_hdr_r, out_hdr_nxt;
  logic                        out_pend_r, out_pend_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_err_r, out_err_nxt;

  logic                        advance;
  logic                        go;
  logic                        in_hdr;
  logic                        grp_last;
  logic [lpf_pkg::GIDX_W-1:0]  gsize;
  logic [lpf_pkg::GIDX_W-1:0]  gidx;
  logic [lpf_pkg::GIDX_W-1:0]  sel;

  assign advance = !out_valid_r || out_if.ready;
  assign go      = head_valid && advance;
  assign in_hdr  = head.hdr && !hdr_done_r;

  always_comb begin
    gsize    = cfg.wide ? lpf_pkg::GIDX_W'(lpf_pkg::GROUP_MAX)
                        : lpf_pkg::GIDX_W'(lpf_pkg::GROUP_PAIR);
    gidx     = lpf_pkg::GIDX_W'(idx_r);
    grp_last = (gidx == gsize - 1'b1);
    sel      = cfg.wide ? lpf_pkg::order24(gidx) : (gidx ^ lpf_pkg::GIDX_W'(1));

    idx_nxt       = idx_r;
    hdr_done_nxt  = hdr_done_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    out_hdr_nxt   = out_hdr_r;
    out_pend_nxt  = out_pend_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    pop           = 1'b0;

    if (go) begin
      out_valid_nxt = 1'b1;
      if (head.err) begin
        out_byte_nxt = 8'h00;
        out_hdr_nxt  = 1'b0;
        out_pend_nxt = 1'b0;
        out_last_nxt = 1'b1;
        out_err_nxt  = 1'b1;
        pop          = 1'b1;
      end else if (in_hdr) begin
        out_byte_nxt = lpf_pkg::hdr_byte(lpf_pkg::HIDX_W'(idx_r), head.fc, cfg.wide,
                                         cfg.rate, cfg.chan);
        out_hdr_nxt  = 1'b1;
        out_pend_nxt = 1'b0;
        out_last_nxt = 1'b0;
        out_err_nxt  = 1'b0;
        if (idx_r == lpf_pkg::IDX_W'(lpf_pkg::HDR_LEN - 1)) begin
          idx_nxt      = '0;
          hdr_done_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        out_byte_nxt = head.data[sel];
        out_hdr_nxt  = 1'b0;
        out_pend_nxt = head.pend && grp_last;
        out_last_nxt = grp_last;
        out_err_nxt  = 1'b0;
        if (grp_last) begin
          idx_nxt      = '0;
          hdr_done_nxt = 1'b0;
          pop          = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      hdr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      hdr_done_r  <= hdr_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_hdr_r  <= out_hdr_nxt;
    out_pend_r <= out_pend_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.is_header   = out_hdr_r;
  assign out_if.packet_end  = out_pend_r;
  assign out_if.run_last    = out_last_r;
  assign out_if.setup_error = out_err_r;

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && !out_hdr_r && !out_pend_r)
    else $error("setup error word carries other flags");

  a_pend_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pend_r |-> out_last_r && !out_hdr_r)
    else $error("packet end not on last payload word of a group");

  a_hdr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_done_r |-> head_valid && head.hdr && !head.err)
    else $error("header marked done without a header job at the head");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < lpf_pkg::IDX_W'(lpf_pkg::HDR_LEN))
    else $error("sequencer index out of range");

endmodule

`default_nettype wire

// File: hdl/lpcm_packet_framer_top.sv
// Top level of the DVD-LPCM packet framer.
`default_nettype none

// Frames a little-endian interleaved PCM byte stream into DVD-LPCM payloads.
// The input takes one PCM word per cycle while its ready is high; the output gives
// one framed word per cycle while the receiver is ready, so a 16-bit pair gives
// two output words and a 24-bit group twelve, and each packet adds a 14-word
// private header in front of its first group. The two-entry job queue between
// the front end and the output sequencer decouples the two; input ready is held
// low while the queue is full.
// After reset and after every register write, frames per packet and payload
// length are derived by repeated addition of the frame size while the sum
// still fits in the packet space, with input ready held low meanwhile. A write
// also restarts the packet (group fill and payload count cleared) while the
// header frame counter keeps running. With an unsupported rate, zero channels
// or a frame too large for one packet, each input word is dropped and answered
// by a single word with setup_error set.
// Registers (32-bit, byte address 4*i): 0 rate_select, 1 channel_count,
// 2 sample_width. buffer_end is carried but has no effect on the output.
module lpcm_packet_framer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lpf_in_if.sink                               in_if,
  lpf_out_if.source                            out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lpf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [lpf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [lpf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  lpf_pkg::lpf_cfg_t  cfg;
  logic               push;
  lpf_pkg::lpf_job_t  push_job;
  logic               q_full;
  logic               head_valid;
  lpf_pkg::lpf_job_t  head;
  logic               pop;

  // Registers and derived packet geometry
  lpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Gather words into groups, classify header and packet end, hand off jobs
  lpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple the word-rate front end from the burst-y output sequencer
  lpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Emit header and reordered payload words through the output register
  lpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire
